[rtl/riproj_pkg.sv]
// shared widths, register indexes and configuration types for the rotate and project block
package riproj_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TRIG_W     = 16;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned SCALE_W    = 8;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned SCREEN_W   = 24;
  localparam int unsigned GRID_MAX_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_A_TRIG    = 3'd0,
    CFG_ROT_B_TRIG    = 3'd1,
    CFG_VIEW_TRIG     = 3'd2,
    CFG_GRID_SCALE    = 3'd3,
    CFG_HEIGHT_SCALE  = 3'd4,
    CFG_CENTER_OFFSET = 3'd5,
    CFG_SCREEN_OFFSET = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [TRIG_W-1:0]  cos_a;
    logic [TRIG_W-1:0]  sin_a;
    logic [TRIG_W-1:0]  cos_b;
    logic [TRIG_W-1:0]  sin_b;
    logic [TRIG_W-1:0]  cos_v;
    logic [TRIG_W-1:0]  sin_v;
    logic [SCALE_W-1:0] grid_scale;
    logic [SCALE_W-1:0] height_scale;
    logic [OFF_W-1:0]   half_w;
    logic [OFF_W-1:0]   half_h;
    logic [OFF_W-1:0]   off_x;
    logic [OFF_W-1:0]   off_y;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cos_a:        16'h4000,
    sin_a:        16'h0000,
    cos_b:        16'h4000,
    sin_b:        16'h0000,
    cos_v:        16'd14189,
    sin_v:        16'd8192,
    grid_scale:   8'd20,
    height_scale: 8'd1,
    half_w:       16'h0000,
    half_h:       16'h0000,
    off_x:        16'h0000,
    off_y:        16'h0000
  };

endpackage

[rtl/riproj_cfg.sv]
// configuration register file, write only
module riproj_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [riproj_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [riproj_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output riproj_pkg::cfg_t                    cfg_o
);

  riproj_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (riproj_pkg::cfg_reg_e'(cfg_idx_i))
        riproj_pkg::CFG_ROT_A_TRIG: begin
          cfg_d.cos_a = cfg_wdata_i[31:16];
          cfg_d.sin_a = cfg_wdata_i[15:0];
        end
        riproj_pkg::CFG_ROT_B_TRIG: begin
          cfg_d.cos_b = cfg_wdata_i[31:16];
          cfg_d.sin_b = cfg_wdata_i[15:0];
        end
        riproj_pkg::CFG_VIEW_TRIG: begin
          cfg_d.cos_v = cfg_wdata_i[31:16];
          cfg_d.sin_v = cfg_wdata_i[15:0];
        end
        riproj_pkg::CFG_GRID_SCALE: begin
          cfg_d.grid_scale = cfg_wdata_i[7:0];
        end
        riproj_pkg::CFG_HEIGHT_SCALE: begin
          cfg_d.height_scale = cfg_wdata_i[7:0];
        end
        riproj_pkg::CFG_CENTER_OFFSET: begin
          cfg_d.half_w = cfg_wdata_i[31:16];
          cfg_d.half_h = cfg_wdata_i[15:0];
        end
        riproj_pkg::CFG_SCREEN_OFFSET: begin
          cfg_d.off_x = cfg_wdata_i[31:16];
          cfg_d.off_y = cfg_wdata_i[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= riproj_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/riproj_tsat.sv]
// divide by a power of two toward zero, then saturate to the output width
module riproj_tsat #(
  parameter int unsigned IW    = 37,
  parameter int unsigned SHIFT = 14,
  parameter int unsigned OW    = 32
) (
  input  logic signed [IW-1:0] val_i,
  output logic signed [OW-1:0] val_o
);

  localparam int unsigned TW = IW - SHIFT;

  logic signed [TW-1:0] tr;

  generate
    if (SHIFT > 0) begin : g_trunc
      logic signed [IW-1:0] adj;
      // bias negative values so the arithmetic shift rounds toward zero
      assign adj = val_i + IW'({SHIFT{val_i[IW-1]}});
      assign tr  = adj[IW-1:SHIFT];
    end else begin : g_pass
      assign tr = val_i;
    end

    if (TW > OW) begin : g_sat
      logic hi_same;
      assign hi_same = (&tr[TW-1:OW-1]) | ~(|tr[TW-1:OW-1]);
      assign val_o   = hi_same ? tr[OW-1:0]
                     : (tr[TW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}});
    end else begin : g_ext
      assign val_o = OW'(tr);
    end
  endgenerate

endmodule

[rtl/riproj_rot.sv]
// two-stage plane rotation: products, then sums with truncation and saturation
module riproj_rot #(
  parameter int unsigned AW        = 20,
  parameter int unsigned BW        = 20,
  parameter int unsigned OW        = 23,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                                     clk_i,
  input  logic [1:0]                               en_i,
  input  logic signed [AW-1:0]                     a_i,
  input  logic signed [BW-1:0]                     b_i,
  input  logic signed [riproj_pkg::TRIG_W-1:0]     cos_i,
  input  logic signed [riproj_pkg::TRIG_W-1:0]     sin_i,
  output logic signed [OW-1:0]                     p_o,
  output logic signed [OW-1:0]                     q_o
);

  localparam int unsigned MW  = (AW > BW) ? AW : BW;
  localparam int unsigned PAW = AW + riproj_pkg::TRIG_W;
  localparam int unsigned PBW = BW + riproj_pkg::TRIG_W;
  localparam int unsigned SW  = MW + riproj_pkg::TRIG_W + 1;

  logic signed [PAW-1:0] ac_q, as_q;
  logic signed [PBW-1:0] bs_q, bc_q;
  logic signed [SW-1:0]  p_sum, q_sum;
  logic signed [OW-1:0]  p_d, q_d, p_q, q_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ac_q <= a_i * cos_i;
      as_q <= a_i * sin_i;
      bs_q <= b_i * sin_i;
      bc_q <= b_i * cos_i;
    end
  end

  assign p_sum = SW'(ac_q) - SW'(bs_q);
  assign q_sum = SW'(as_q) + SW'(bc_q);

  riproj_tsat #(.IW(SW), .SHIFT(FRAC_BITS), .OW(OW)) u_tsat_p (
    .val_i (p_sum),
    .val_o (p_d)
  );

  riproj_tsat #(.IW(SW), .SHIFT(FRAC_BITS), .OW(OW)) u_tsat_q (
    .val_i (q_sum),
    .val_o (q_d)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q <= p_d;
      q_q <= q_d;
    end
  end

  assign p_o = p_q;
  assign q_o = q_q;

endmodule

[rtl/riproj_proj.sv]
// four-stage isometric projection with screen offset and 24-bit saturation
module riproj_proj #(
  parameter int unsigned XW        = 27,
  parameter int unsigned YW        = 23,
  parameter int unsigned ZW        = 27,
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                                       clk_i,
  input  logic [3:0]                                 en_i,
  input  logic signed [XW-1:0]                       x2_i,
  input  logic signed [YW-1:0]                       y1_i,
  input  logic signed [ZW-1:0]                       z2_i,
  input  logic signed [riproj_pkg::TRIG_W-1:0]       cos_i,
  input  logic signed [riproj_pkg::TRIG_W-1:0]       sin_i,
  input  logic signed [riproj_pkg::OFF_W-1:0]        off_x_i,
  input  logic signed [riproj_pkg::OFF_W-1:0]        off_y_i,
  output logic signed [riproj_pkg::SCREEN_W-1:0]     screen_x_o,
  output logic signed [riproj_pkg::SCREEN_W-1:0]     screen_y_o
);

  localparam int unsigned DW  = ((XW > YW) ? XW : YW) + 1;
  localparam int unsigned MW  = DW + riproj_pkg::TRIG_W;
  localparam int unsigned PXW = MW - FRAC_BITS;
  localparam int unsigned ZSW = ZW + 1 + FRAC_BITS;
  localparam int unsigned YSW = ((ZSW > MW) ? ZSW : MW) + 1;
  localparam int unsigned PYW = YSW - FRAC_BITS;
  localparam int unsigned AXW = ((PXW > riproj_pkg::OFF_W) ? PXW : riproj_pkg::OFF_W) + 1;
  localparam int unsigned AYW = ((PYW > riproj_pkg::OFF_W) ? PYW : riproj_pkg::OFF_W) + 1;

  logic signed [DW-1:0]  d_q, s_q;
  logic signed [ZW-1:0]  za_q, zb_q;
  logic signed [MW-1:0]  pd_q, ps_q;
  logic signed [YSW-1:0] py_sum;
  logic signed [PXW-1:0] px_d, px_q;
  logic signed [PYW-1:0] py_d, py_q;
  logic signed [AXW-1:0] sx_sum;
  logic signed [AYW-1:0] sy_sum;
  logic signed [riproj_pkg::SCREEN_W-1:0] sx_d, sy_d, sx_q, sy_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d_q  <= DW'(x2_i) - DW'(y1_i);
      s_q  <= DW'(x2_i) + DW'(y1_i);
      za_q <= z2_i;
    end
    if (en_i[1]) begin
      pd_q <= d_q * cos_i;
      ps_q <= s_q * sin_i;
      zb_q <= za_q;
    end
  end

  assign py_sum = YSW'(ps_q) - (YSW'(zb_q) <<< FRAC_BITS);

  riproj_tsat #(.IW(MW), .SHIFT(FRAC_BITS), .OW(PXW)) u_tsat_px (
    .val_i (pd_q),
    .val_o (px_d)
  );

  riproj_tsat #(.IW(YSW), .SHIFT(FRAC_BITS), .OW(PYW)) u_tsat_py (
    .val_i (py_sum),
    .val_o (py_d)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      px_q <= px_d;
      py_q <= py_d;
    end
  end

  assign sx_sum = AXW'(px_q) + AXW'(off_x_i);
  assign sy_sum = AYW'(py_q) + AYW'(off_y_i);

  riproj_tsat #(.IW(AXW), .SHIFT(0), .OW(riproj_pkg::SCREEN_W)) u_sat_x (
    .val_i (sx_sum),
    .val_o (sx_d)
  );

  riproj_tsat #(.IW(AYW), .SHIFT(0), .OW(riproj_pkg::SCREEN_W)) u_sat_y (
    .val_i (sy_sum),
    .val_o (sy_d)
  );

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
  end

  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;

endmodule

[rtl/rotate_and_isometric_project_top.sv]
// top level: grid point to screen position, rotation and isometric projection pipeline
// One word is taken every clock cycle while in_stall_o is low, and each word passes
// through nine registered stages before it is presented at the output:
// one stage scales and centers the point, each of the two rotations
// takes a multiply stage and a sum/round stage, and the projection takes four stages
// (difference and sum, multiply, round, offset and clip). Every stage holds its own
// valid bit and moves whenever the stage after it is empty or moving, so a stall at
// the output only stops the words behind it, and empty stages keep filling until all
// nine hold a word. Configuration writes take effect on the next cycle and should be
// made while the pipeline is empty.
module rotate_and_isometric_project_top #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned GRID_BITS = 10
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [riproj_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [riproj_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [GRID_BITS-1:0]                     grid_col_i,
  input  logic [GRID_BITS-1:0]                     grid_row_i,
  input  logic signed [riproj_pkg::HEIGHT_W-1:0]   height_i,
  input  logic [riproj_pkg::COLOR_W-1:0]           pixel_color_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [riproj_pkg::SCREEN_W-1:0]   screen_x_o,
  output logic signed [riproj_pkg::SCREEN_W-1:0]   screen_y_o,
  output logic [riproj_pkg::COLOR_W-1:0]           out_color_o
);

  localparam int unsigned NS       = 9;
  localparam int unsigned COL_BITS = (GRID_BITS < riproj_pkg::GRID_MAX_W) ?
                                     GRID_BITS : riproj_pkg::GRID_MAX_W;
  localparam int unsigned CSW      = COL_BITS + riproj_pkg::SCALE_W;
  localparam int unsigned XW       = (((CSW + 1) > riproj_pkg::OFF_W) ?
                                     (CSW + 1) : riproj_pkg::OFF_W) + 1;
  localparam int unsigned ZW       = riproj_pkg::HEIGHT_W + riproj_pkg::SCALE_W;
  localparam int unsigned TWA      = XW + riproj_pkg::TRIG_W + 1 - FRAC_BITS;
  localparam int unsigned X1W      = (TWA > 32) ? 32 : TWA;
  localparam int unsigned MBW      = (X1W > ZW) ? X1W : ZW;
  localparam int unsigned TWB      = MBW + riproj_pkg::TRIG_W + 1 - FRAC_BITS;
  localparam int unsigned X2W      = (TWB > 32) ? 32 : TWB;

  riproj_pkg::cfg_t cfg;

  logic [NS:0]   ld;
  logic [NS-1:0] vld_q;

  logic [COL_BITS-1:0]              col, row;
  logic [CSW-1:0]                   col_prod, row_prod;
  logic signed [XW-1:0]             x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0]             z_d;
  logic signed [ZW-1:0]             z_q [3];
  logic signed [X1W-1:0]            x1, y1;
  logic signed [X1W-1:0]            y1_q [2];
  logic signed [X2W-1:0]            x2, z2;
  logic [riproj_pkg::COLOR_W-1:0]   color_q [NS];

  riproj_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // a stage may load when it is empty or the stage after it loads
  always_comb begin
    ld[NS] = !out_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !ld[0];
  assign out_valid_o = vld_q[NS-1];

  // scale and center
  assign col      = grid_col_i[COL_BITS-1:0];
  assign row      = grid_row_i[COL_BITS-1:0];
  assign col_prod = col * cfg.grid_scale;
  assign row_prod = row * cfg.grid_scale;
  assign x_d      = XW'($signed({1'b0, col_prod})) - XW'($signed(cfg.half_w));
  assign y_d      = XW'($signed({1'b0, row_prod})) - XW'($signed(cfg.half_h));
  assign z_d      = height_i * $signed(cfg.height_scale);

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      x_q        <= x_d;
      y_q        <= y_d;
      z_q[0]     <= z_d;
      color_q[0] <= pixel_color_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (ld[k]) begin
        color_q[k] <= color_q[k-1];
      end
    end
    for (int k = 1; k < 3; k++) begin
      if (ld[k]) begin
        z_q[k] <= z_q[k-1];
      end
    end
    if (ld[3]) begin
      y1_q[0] <= y1;
    end
    if (ld[4]) begin
      y1_q[1] <= y1_q[0];
    end
  end

  riproj_rot #(.AW(XW), .BW(XW), .OW(X1W), .FRAC_BITS(FRAC_BITS)) u_rot_a (
    .clk_i (clk_i),
    .en_i  (ld[2:1]),
    .a_i   (x_q),
    .b_i   (y_q),
    .cos_i ($signed(cfg.cos_a)),
    .sin_i ($signed(cfg.sin_a)),
    .p_o   (x1),
    .q_o   (y1)
  );

  riproj_rot #(.AW(X1W), .BW(ZW), .OW(X2W), .FRAC_BITS(FRAC_BITS)) u_rot_b (
    .clk_i (clk_i),
    .en_i  (ld[4:3]),
    .a_i   (x1),
    .b_i   (z_q[2]),
    .cos_i ($signed(cfg.cos_b)),
    .sin_i ($signed(cfg.sin_b)),
    .p_o   (x2),
    .q_o   (z2)
  );

  riproj_proj #(.XW(X2W), .YW(X1W), .ZW(X2W), .FRAC_BITS(FRAC_BITS)) u_proj (
    .clk_i      (clk_i),
    .en_i       (ld[8:5]),
    .x2_i       (x2),
    .y1_i       (y1_q[1]),
    .z2_i       (z2),
    .cos_i      ($signed(cfg.cos_v)),
    .sin_i      ($signed(cfg.sin_v)),
    .off_x_i    ($signed(cfg.off_x)),
    .off_y_i    ($signed(cfg.off_y)),
    .screen_x_o (screen_x_o),
    .screen_y_o (screen_y_o)
  );

  assign out_color_o = color_q[NS-1];

  a_stall_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q)
  ) else $error("input stalled while a stage is empty");

  a_ready_output_accepts: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o
  ) else $error("input stalled while output is taking words");

  a_last_stage_fills: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NS-2] && ld[NS-1]) |=> vld_q[NS-1]
  ) else $error("word lost entering the output stage");

endmodule

[tb/sv/tb.sv]
// testbench for the rotate and isometric project block: predicts screen words and checks them
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIPE_DEPTH     = 9;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_POINTS   = 100;
  localparam logic [riproj_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct {
    logic [riproj_pkg::SCREEN_W-1:0] x;
    logic [riproj_pkg::SCREEN_W-1:0] y;
    logic [riproj_pkg::COLOR_W-1:0]  color;
  } screen_word_t;

  class projection_scoreboard;
    localparam longint Q_ONE   = 64'sd16384;
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S24_MAX = 64'sd8388607;
    localparam longint S24_MIN = -64'sd8388608;

    logic [riproj_pkg::CFG_DATA_W-1:0] regs [7];
    screen_word_t                      expected_screen [$];
    int unsigned                       n_errors;

    function new();
      regs[riproj_pkg::CFG_ROT_A_TRIG]    = 32'h4000_0000;
      regs[riproj_pkg::CFG_ROT_B_TRIG]    = 32'h4000_0000;
      regs[riproj_pkg::CFG_VIEW_TRIG]     = 32'd929898496;
      regs[riproj_pkg::CFG_GRID_SCALE]    = 32'd20;
      regs[riproj_pkg::CFG_HEIGHT_SCALE]  = 32'd1;
      regs[riproj_pkg::CFG_CENTER_OFFSET] = 32'd0;
      regs[riproj_pkg::CFG_SCREEN_OFFSET] = 32'd0;
      n_errors = 0;
    endfunction

    function void set_reg(logic [riproj_pkg::CFG_IDX_W-1:0] idx,
                          logic [riproj_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        riproj_pkg::CFG_GRID_SCALE, riproj_pkg::CFG_HEIGHT_SCALE:
          regs[idx] = {24'd0, data[7:0]};
        riproj_pkg::CFG_ROT_A_TRIG, riproj_pkg::CFG_ROT_B_TRIG, riproj_pkg::CFG_VIEW_TRIG,
        riproj_pkg::CFG_CENTER_OFFSET, riproj_pkg::CFG_SCREEN_OFFSET:
          regs[idx] = data;
        default: ;
      endcase
    endfunction

    function longint hi_half(logic [31:0] v);
      return longint'($signed(v[31:16]));
    endfunction

    function longint lo_half(logic [31:0] v);
      return longint'($signed(v[15:0]));
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // divide by 2^14, truncating toward zero
    function longint q_trunc(longint v);
      return v / Q_ONE;
    endfunction

    function screen_word_t project_point(logic [9:0] col, logic [9:0] row,
                                         logic signed [15:0] h, logic [23:0] color);
      screen_word_t w;
      longint x, y, z, x1, y1, x2, z2, px, py, sx, sy;
      longint ca, sa, cb, sb, cv, sv;
      x  = longint'(col) * longint'(regs[riproj_pkg::CFG_GRID_SCALE][7:0])
           - hi_half(regs[riproj_pkg::CFG_CENTER_OFFSET]);
      y  = longint'(row) * longint'(regs[riproj_pkg::CFG_GRID_SCALE][7:0])
           - lo_half(regs[riproj_pkg::CFG_CENTER_OFFSET]);
      z  = longint'(h) * longint'($signed(regs[riproj_pkg::CFG_HEIGHT_SCALE][7:0]));
      ca = hi_half(regs[riproj_pkg::CFG_ROT_A_TRIG]);
      sa = lo_half(regs[riproj_pkg::CFG_ROT_A_TRIG]);
      cb = hi_half(regs[riproj_pkg::CFG_ROT_B_TRIG]);
      sb = lo_half(regs[riproj_pkg::CFG_ROT_B_TRIG]);
      cv = hi_half(regs[riproj_pkg::CFG_VIEW_TRIG]);
      sv = lo_half(regs[riproj_pkg::CFG_VIEW_TRIG]);
      x1 = clip(q_trunc(x * ca - y * sa), S32_MIN, S32_MAX);
      y1 = clip(q_trunc(x * sa + y * ca), S32_MIN, S32_MAX);
      x2 = clip(q_trunc(x1 * cb - z * sb), S32_MIN, S32_MAX);
      z2 = clip(q_trunc(x1 * sb + z * cb), S32_MIN, S32_MAX);
      px = q_trunc((x2 - y1) * cv);
      py = q_trunc(-z2 * Q_ONE + (x2 + y1) * sv);
      sx = clip(px + hi_half(regs[riproj_pkg::CFG_SCREEN_OFFSET]), S24_MIN, S24_MAX);
      sy = clip(py + lo_half(regs[riproj_pkg::CFG_SCREEN_OFFSET]), S24_MIN, S24_MAX);
      w.x     = sx[23:0];
      w.y     = sy[23:0];
      w.color = color;
      return w;
    endfunction

    function void note_point(logic [9:0] col, logic [9:0] row,
                             logic signed [15:0] h, logic [23:0] color);
      expected_screen.push_back(project_point(col, row, h, color));
    endfunction

    task report_mismatch(string field, logic [23:0] got, logic [23:0] want);
      $display("mismatch %s: got %h want %h", field, got, want);
      n_errors++;
    endtask

    task check_screen(logic [23:0] x, logic [23:0] y, logic [23:0] color);
      screen_word_t w;
      if (expected_screen.size() == 0) begin
        report_mismatch("unexpected word x", x, 24'd0);
      end else begin
        w = expected_screen.pop_front();
        if (x !== w.x) report_mismatch("screen_x", x, w.x);
        if (y !== w.y) report_mismatch("screen_y", y, w.y);
        if (color !== w.color) report_mismatch("out_color", color, w.color);
      end
    endtask

    function int unsigned pending();
      return expected_screen.size();
    endfunction
  endclass

  logic                                    clk_i;
  logic                                    rst_ni;
  logic                                    cfg_we_i;
  logic [riproj_pkg::CFG_IDX_W-1:0]        cfg_idx_i;
  logic [riproj_pkg::CFG_DATA_W-1:0]       cfg_wdata_i;
  logic                                    in_valid_i;
  logic                                    in_stall_o;
  logic [9:0]                              grid_col_i;
  logic [9:0]                              grid_row_i;
  logic signed [riproj_pkg::HEIGHT_W-1:0]  height_i;
  logic [riproj_pkg::COLOR_W-1:0]          pixel_color_i;
  logic                                    out_valid_o;
  logic                                    out_stall_i;
  logic signed [riproj_pkg::SCREEN_W-1:0]  screen_x_o;
  logic signed [riproj_pkg::SCREEN_W-1:0]  screen_y_o;
  logic [riproj_pkg::COLOR_W-1:0]          out_color_o;

  logic        tx_idle_en;
  logic        rx_idle_en;
  logic        hold_req;
  int unsigned hold_cnt;
  int unsigned idle_cycles;

  projection_scoreboard sb;

  rotate_and_isometric_project_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .grid_col_i    (grid_col_i),
    .grid_row_i    (grid_row_i),
    .height_i      (height_i),
    .pixel_color_i (pixel_color_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .screen_x_o    (screen_x_o),
    .screen_y_o    (screen_y_o),
    .out_color_o   (out_color_o)
  );

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = riproj_pkg::CFG_ROT_A_TRIG;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    grid_col_i    = '0;
    grid_row_i    = '0;
    height_i      = '0;
    pixel_color_i = '0;
    out_stall_i   = 1'b0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    hold_req      = 1'b0;
    hold_cnt      = 0;
    idle_cycles   = 0;
  end

  always #5 clk_i = ~clk_i;

  // receiver side: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt + 1;
    end else begin
      out_stall_i <= rx_idle_en && ($urandom_range(0, 99) < 34);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_point(grid_col_i, grid_row_i, height_i, pixel_color_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_screen(screen_x_o, screen_y_o, out_color_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task send_point(logic [9:0] col, logic [9:0] row, logic signed [15:0] h, logic [23:0] color);
    if (tx_idle_en) begin
      while ($urandom_range(0, 99) < 34) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    grid_col_i    <= col;
    grid_row_i    <= row;
    height_i      <= h;
    pixel_color_i <= color;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task send_random_point();
    send_point(10'($urandom), 10'($urandom), 16'($urandom), 24'($urandom));
  endtask

  // drop valid and wait until every word has come out
  task drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task write_reg(logic [riproj_pkg::CFG_IDX_W-1:0] idx,
                 logic [riproj_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function logic [31:0] trig_pair();
    logic [15:0] c, s;
    if ($urandom_range(0, 1)) return $urandom;
    c = 16'($urandom_range(0, 32768) - 16384);
    s = 16'($urandom_range(0, 32768) - 16384);
    return {c, s};
  endfunction

  task random_config();
    write_reg(riproj_pkg::CFG_ROT_A_TRIG, trig_pair());
    write_reg(riproj_pkg::CFG_ROT_B_TRIG, trig_pair());
    write_reg(riproj_pkg::CFG_VIEW_TRIG, trig_pair());
    write_reg(riproj_pkg::CFG_GRID_SCALE, 32'($urandom_range(0, 255)));
    write_reg(riproj_pkg::CFG_HEIGHT_SCALE, 32'($urandom_range(0, 255)));
    write_reg(riproj_pkg::CFG_CENTER_OFFSET, $urandom);
    write_reg(riproj_pkg::CFG_SCREEN_OFFSET, $urandom);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, field extremes
    send_point(10'd0, 10'd0, 16'sd0, 24'h000000);
    send_point(10'd1023, 10'd1023, 16'sd32767, 24'hffffff);
    send_point(10'd0, 10'd1023, -16'sd32768, 24'h5a5a5a);
    send_point(10'd1023, 10'd0, -16'sd1, 24'ha5a5a5);
    send_point(10'd512, 10'd511, 16'sd1, 24'h123456);
    drain();

    // extreme settings, screen saturation both ways, ignored index
    write_reg(riproj_pkg::CFG_ROT_A_TRIG, 32'h8000_8000);
    write_reg(riproj_pkg::CFG_ROT_B_TRIG, 32'h8000_7fff);
    write_reg(riproj_pkg::CFG_VIEW_TRIG, 32'h8000_8000);
    write_reg(riproj_pkg::CFG_GRID_SCALE, 32'd255);
    write_reg(riproj_pkg::CFG_HEIGHT_SCALE, 32'h80);
    write_reg(riproj_pkg::CFG_CENTER_OFFSET, 32'h8000_8000);
    write_reg(riproj_pkg::CFG_SCREEN_OFFSET, 32'h7fff_8000);
    write_reg(CFG_UNUSED, 32'hffff_ffff);
    send_point(10'd1023, 10'd1023, -16'sd32768, 24'h800001);
    send_point(10'd0, 10'd0, 16'sd32767, 24'h7ffffe);
    send_point(10'd1023, 10'd0, 16'sd32767, 24'h00ff00);
    send_point(10'd0, 10'd1023, -16'sd32768, 24'hff00ff);
    drain();

    // zero grid scale and positive extremes
    write_reg(riproj_pkg::CFG_ROT_A_TRIG, 32'h7fff_7fff);
    write_reg(riproj_pkg::CFG_ROT_B_TRIG, 32'h7fff_8000);
    write_reg(riproj_pkg::CFG_VIEW_TRIG, 32'h7fff_7fff);
    write_reg(riproj_pkg::CFG_GRID_SCALE, 32'd0);
    write_reg(riproj_pkg::CFG_HEIGHT_SCALE, 32'h7f);
    write_reg(riproj_pkg::CFG_CENTER_OFFSET, 32'h7fff_7fff);
    write_reg(riproj_pkg::CFG_SCREEN_OFFSET, 32'h8000_7fff);
    send_point(10'd1023, 10'd1023, 16'sd32767, 24'h0f0f0f);
    send_point(10'd0, 10'd0, -16'sd32768, 24'hf0f0f0);
    send_point(10'd341, 10'd682, 16'sd100, 24'h3c3c3c);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      tx_idle_en = (p != 2) && (p != 4);
      rx_idle_en = (p != 2);
      hold_req   = (p == 4);
      for (int i = 0; i < PHASE_POINTS; i++) send_random_point();
      drain();
    end

    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/riproj_pkg.sv
rtl/riproj_cfg.sv
rtl/riproj_tsat.sv
rtl/riproj_rot.sv
rtl/riproj_proj.sv
rtl/rotate_and_isometric_project_top.sv
tb/sv/tb.sv
